/* rtl/core/cws_pkg.sv */
// Shared constants, codes and types of the congestion window sender.
package cws_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned PEER_W     = 13;
  localparam int unsigned DUP_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(1024);
  localparam logic [CNT_W-1:0] WIN_LIMIT   = CNT_W'(4095);
  localparam logic [CNT_W-1:0] RING_CAP    = CNT_W'(RING_DEPTH - 1);
  localparam logic [DUP_W-1:0] DUP_TRIGGER = DUP_W'(3);
  localparam logic [DUP_W-1:0] DUP_SAT     = DUP_W'(4);

  localparam logic [SEQ_W-1:0] START_SEQ_RST = '0;
  localparam logic [THR_W-1:0] INIT_THR_RST  = THR_W'(2048);

  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TMO  = 2'd2,
    CMD_SEND = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } seg_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    seg_t             wdata;
    logic [PTR_W-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic             send_valid;
    logic [PTR_W-1:0] send_slot;
    logic [SEQ_W-1:0] send_seq;
    logic [LEN_W-1:0] send_len;
    logic             enq_accepted;
    logic [CNT_W-1:0] released;
    logic             retransmit;
    logic [CNT_W-1:0] window;
    logic [THR_W-1:0] threshold;
    logic [CNT_W-1:0] queued;
    logic [CNT_W-1:0] in_flight;
  } result_t;

endpackage

/* rtl/core/cws_ring.sv */
// Segment ring storage: one write port, one read port with registered data.
module cws_ring (
  input  logic                clk_i,
  input  cws_pkg::ring_req_t  req_i,
  output cws_pkg::seg_t       rdata_o
);

  cws_pkg::seg_t mem [cws_pkg::RING_DEPTH];
  cws_pkg::seg_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cws_engine.sv */
// Event sequencer: pointers, counters and window control around the ring.
module cws_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cws_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cws_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          cmd_i,
  input  logic [cws_pkg::LEN_W-1:0]           seg_len_i,
  input  logic [cws_pkg::SEQ_W-1:0]           ack_no_i,
  input  logic [cws_pkg::PEER_W-1:0]          peer_window_i,
  input  logic                                res_free_i,
  output logic                                res_load_o,
  output cws_pkg::result_t                    res_o,
  output cws_pkg::ring_req_t                  ring_req_o,
  input  cws_pkg::seg_t                       ring_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ENQ  = 5'b00010,
    S_ACK  = 5'b00100,
    S_TMO  = 5'b01000,
    S_SEND = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [cws_pkg::SEQ_W-1:0]  start_seq_q, start_seq_d;
  logic [cws_pkg::THR_W-1:0]  init_thr_q, init_thr_d;
  logic [cws_pkg::PTR_W-1:0]  head_q, head_d, send_ptr_q, send_ptr_d, tail_q, tail_d;
  logic [cws_pkg::CNT_W-1:0]  queue_q, queue_d, sent_q, sent_d;
  logic [cws_pkg::SEQ_W-1:0]  oldest_q, oldest_d, next_seq_q, next_seq_d;
  logic [cws_pkg::CNT_W-1:0]  cwnd_q, cwnd_d, avoid_q, avoid_d;
  logic [cws_pkg::THR_W-1:0]  thr_q, thr_d;
  logic [cws_pkg::SEQ_W-1:0]  last_ack_q, last_ack_d;
  logic [cws_pkg::DUP_W-1:0]  dup_q, dup_d;

  // operands of the item in progress
  logic [cws_pkg::LEN_W-1:0]  len_q, len_d;
  logic [cws_pkg::SEQ_W-1:0]  ack_q, ack_d;
  logic [cws_pkg::PEER_W-1:0] peer_q, peer_d;
  logic [cws_pkg::SEQ_W-1:0]  remain_q, remain_d;
  logic                       in_range_q, in_range_d;
  logic [cws_pkg::CNT_W-1:0]  rel_q, rel_d;

  // one release step, from the head entry read last cycle
  logic [cws_pkg::PTR_W-1:0]  head_nx, sptr_t;
  logic [cws_pkg::CNT_W-1:0]  sent_t, cw_t, av_t;
  logic [cws_pkg::THR_W-1:0]  thr_t, half_thr;
  logic [cws_pkg::THR_W:0]    thr_sum;
  logic [cws_pkg::DUP_W-1:0]  dup_nx;
  logic [cws_pkg::LEN_W-1:0]  len_sat;
  logic [cws_pkg::CNT_W-1:0]  lim;
  logic [cws_pkg::THR_W-1:0]  cfg_thr;
  logic                       go, in_acc;

  assign in_stall_o = (state_q != S_IDLE) || cfg_we_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    head_nx = head_q + cws_pkg::PTR_W'(1);
    if (sent_q == '0) begin
      sent_t = '0;
      sptr_t = head_nx;
    end else begin
      sent_t = sent_q - cws_pkg::CNT_W'(1);
      sptr_t = send_ptr_q;
    end
    av_t  = avoid_q;
    cw_t  = cwnd_q;
    thr_t = thr_q;
    if (cwnd_q >= thr_q) begin
      av_t = avoid_q + cws_pkg::CNT_W'(1);
      if (av_t == cwnd_q) begin
        av_t = '0;
        if (cwnd_q < cws_pkg::WIN_LIMIT) begin
          cw_t  = cwnd_q + cws_pkg::CNT_W'(1);
          thr_t = thr_q + cws_pkg::THR_W'(1);
        end
      end
    end else if (cwnd_q < cws_pkg::WIN_LIMIT) begin
      cw_t = cwnd_q + cws_pkg::CNT_W'(1);
    end
    if ({1'b0, cw_t} > peer_q) begin
      cw_t = peer_q[cws_pkg::CNT_W-1:0];
    end
    // trim the in-flight span down to the new window
    if (cw_t < sent_t) begin
      sptr_t = head_nx + cws_pkg::PTR_W'(cw_t);
      sent_t = cw_t;
    end
  end

  assign go = in_range_q && (queue_q != '0) && (remain_q != '0) &&
              ({{(cws_pkg::SEQ_W-cws_pkg::LEN_W){1'b0}}, ring_rdata_i.len} <= remain_q);

  assign dup_nx   = (dup_q == cws_pkg::DUP_SAT) ? dup_q : dup_q + cws_pkg::DUP_W'(1);
  assign thr_sum  = {1'b0, thr_q} + (cws_pkg::THR_W+1)'(1);
  assign half_thr = thr_sum[cws_pkg::THR_W:1];
  assign len_sat  = (len_q > cws_pkg::MAX_PAYLOAD) ? cws_pkg::MAX_PAYLOAD : len_q;
  assign lim      = (cwnd_q < queue_q) ? cwnd_q : queue_q;
  assign cfg_thr  = cfg_data_i[cws_pkg::THR_W-1:0];

  always_comb begin
    state_d     = state_q;
    start_seq_d = start_seq_q;
    init_thr_d  = init_thr_q;
    head_d      = head_q;
    send_ptr_d  = send_ptr_q;
    tail_d      = tail_q;
    queue_d     = queue_q;
    sent_d      = sent_q;
    oldest_d    = oldest_q;
    next_seq_d  = next_seq_q;
    cwnd_d      = cwnd_q;
    avoid_d     = avoid_q;
    thr_d       = thr_q;
    last_ack_d  = last_ack_q;
    dup_d       = dup_q;
    len_d       = len_q;
    ack_d       = ack_q;
    peer_d      = peer_q;
    remain_d    = remain_q;
    in_range_d  = in_range_q;
    rel_d       = rel_q;

    res_load_o       = 1'b0;
    ring_req_o.we    = 1'b0;
    ring_req_o.waddr = tail_q;
    ring_req_o.wdata = '{seq: next_seq_q, len: len_sat};

    res_o              = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          // restart the session from the register contents
          head_d     = '0;
          send_ptr_d = '0;
          tail_d     = '0;
          queue_d    = '0;
          sent_d     = '0;
          cwnd_d     = cws_pkg::CNT_W'(1);
          avoid_d    = '0;
          dup_d      = '0;
          oldest_d   = start_seq_q;
          next_seq_d = start_seq_q;
          last_ack_d = start_seq_q;
          thr_d      = (init_thr_q != '0) ? init_thr_q : cws_pkg::THR_W'(1);
          unique case (cfg_idx_i)
            cws_pkg::REG_START_SEQ: begin
              start_seq_d = cfg_data_i[cws_pkg::SEQ_W-1:0];
              oldest_d    = cfg_data_i[cws_pkg::SEQ_W-1:0];
              next_seq_d  = cfg_data_i[cws_pkg::SEQ_W-1:0];
              last_ack_d  = cfg_data_i[cws_pkg::SEQ_W-1:0];
            end
            cws_pkg::REG_INIT_THR: begin
              init_thr_d = cfg_thr;
              thr_d      = (cfg_thr != '0) ? cfg_thr : cws_pkg::THR_W'(1);
            end
            default: ;
          endcase
        end else if (in_acc) begin
          len_d      = seg_len_i;
          ack_d      = ack_no_i;
          peer_d     = peer_window_i;
          remain_d   = ack_no_i - oldest_q;
          in_range_d = (ack_no_i - oldest_q) <= (next_seq_q - oldest_q);
          rel_d      = '0;
          unique case (cws_pkg::cmd_e'(cmd_i))
            cws_pkg::CMD_ENQ:  state_d = S_ENQ;
            cws_pkg::CMD_ACK:  state_d = S_ACK;
            cws_pkg::CMD_TMO:  state_d = S_TMO;
            cws_pkg::CMD_SEND: state_d = S_SEND;
            default:           state_d = S_IDLE;
          endcase
        end
      end

      S_ENQ: begin
        if (res_free_i) begin
          if ((len_sat != '0) && (queue_q < cws_pkg::RING_CAP)) begin
            ring_req_o.we      = 1'b1;
            next_seq_d         = next_seq_q +
                                 {{(cws_pkg::SEQ_W-cws_pkg::LEN_W){1'b0}}, len_sat};
            tail_d             = tail_q + cws_pkg::PTR_W'(1);
            queue_d            = queue_q + cws_pkg::CNT_W'(1);
            res_o.enq_accepted = 1'b1;
          end
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_ACK: begin
        if (go) begin
          // release the head segment and read the one behind it
          remain_d   = remain_q -
                       {{(cws_pkg::SEQ_W-cws_pkg::LEN_W){1'b0}}, ring_rdata_i.len};
          oldest_d   = oldest_q +
                       {{(cws_pkg::SEQ_W-cws_pkg::LEN_W){1'b0}}, ring_rdata_i.len};
          head_d     = head_nx;
          queue_d    = queue_q - cws_pkg::CNT_W'(1);
          rel_d      = rel_q + cws_pkg::CNT_W'(1);
          send_ptr_d = sptr_t;
          sent_d     = sent_t;
          cwnd_d     = cw_t;
          avoid_d    = av_t;
          thr_d      = thr_t;
        end else if (res_free_i) begin
          if (ack_q == last_ack_q) begin
            dup_d = dup_nx;
            if (dup_nx == cws_pkg::DUP_TRIGGER) begin
              thr_d            = half_thr;
              cwnd_d           = cws_pkg::CNT_W'(1) + (cwnd_q >> 1);
              send_ptr_d       = head_q;
              sent_d           = '0;
              avoid_d          = '0;
              res_o.retransmit = 1'b1;
            end
          end else begin
            last_ack_d = ack_q;
            dup_d      = '0;
          end
          res_o.released = rel_q;
          res_load_o     = 1'b1;
          state_d        = S_IDLE;
        end
      end

      S_TMO: begin
        if (res_free_i) begin
          if (sent_q != '0) begin
            thr_d            = half_thr;
            cwnd_d           = cws_pkg::CNT_W'(1);
            send_ptr_d       = head_q;
            sent_d           = '0;
            avoid_d          = '0;
            res_o.retransmit = 1'b1;
          end
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_SEND: begin
        if (res_free_i) begin
          if (sent_q < lim) begin
            res_o.send_valid = 1'b1;
            res_o.send_slot  = send_ptr_q;
            res_o.send_seq   = ring_rdata_i.seq;
            res_o.send_len   = ring_rdata_i.len;
            send_ptr_d       = send_ptr_q + cws_pkg::PTR_W'(1);
            sent_d           = sent_q + cws_pkg::CNT_W'(1);
          end
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    res_o.window    = cwnd_d;
    res_o.threshold = thr_d;
    res_o.queued    = queue_d;
    res_o.in_flight = sent_d;

    // hold the send entry on the read port while a send waits; else track the head
    ring_req_o.raddr = ((state_q == S_SEND) ||
                        ((state_q == S_IDLE) && (cmd_i == cws_pkg::CMD_SEND)))
                       ? send_ptr_q : head_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_seq_q <= cws_pkg::START_SEQ_RST;
      init_thr_q  <= cws_pkg::INIT_THR_RST;
      head_q      <= '0;
      send_ptr_q  <= '0;
      tail_q      <= '0;
      queue_q     <= '0;
      sent_q      <= '0;
      oldest_q    <= cws_pkg::START_SEQ_RST;
      next_seq_q  <= cws_pkg::START_SEQ_RST;
      cwnd_q      <= cws_pkg::CNT_W'(1);
      avoid_q     <= '0;
      thr_q       <= cws_pkg::INIT_THR_RST;
      last_ack_q  <= cws_pkg::START_SEQ_RST;
      dup_q       <= '0;
    end else begin
      state_q     <= state_d;
      start_seq_q <= start_seq_d;
      init_thr_q  <= init_thr_d;
      head_q      <= head_d;
      send_ptr_q  <= send_ptr_d;
      tail_q      <= tail_d;
      queue_q     <= queue_d;
      sent_q      <= sent_d;
      oldest_q    <= oldest_d;
      next_seq_q  <= next_seq_d;
      cwnd_q      <= cwnd_d;
      avoid_q     <= avoid_d;
      thr_q       <= thr_d;
      last_ack_q  <= last_ack_d;
      dup_q       <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    ack_q      <= ack_d;
    peer_q     <= peer_d;
    remain_q   <= remain_d;
    in_range_q <= in_range_d;
    rel_q      <= rel_d;
  end

endmodule

/* rtl/core/cws_out_reg.sv */
// Result register between the sequencer and the output channel.
module cws_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cws_pkg::result_t  res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cws_pkg::result_t  res_o
);

  logic             valid_q, valid_d;
  cws_pkg::result_t res_q, res_d;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/congestion_window_sender.sv */
// Top level of the congestion window sender: ring, sequencer and result register.
//
// Input channel (valid/stall): one event per transfer, cmd_i selects enqueue,
// ack, timeout or send; seg_len_i, ack_no_i and peer_window_i ride along.
// Output channel (valid/stall): exactly one result per event, carrying the
// issued segment, enqueue and release status, the retransmit flag and the
// window, threshold, queued and in-flight counts after the event.
// Enqueue, timeout and send pass through their sequencer state into the result register;
// an ack first runs a release loop over the segments it covers, and the release loop
// reads one ring entry per cycle through the registered read port.
// A new event is taken as soon as the sequencer is back in idle, even while
// the previous result still waits in the output register; a stalled receiver
// holds the sequencer in its final step until the result register frees.
// The configuration port writes start_seq (index 0) or initial_threshold
// (index 1) while idle; each write restarts the session with an empty ring.
// Reset empties the ring at once; the segment storage needs no clearing.
module congestion_window_sender (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cws_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cws_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [cws_pkg::LEN_W-1:0]      seg_len_i,
  input  logic [cws_pkg::SEQ_W-1:0]      ack_no_i,
  input  logic [cws_pkg::PEER_W-1:0]     peer_window_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           send_valid_o,
  output logic [cws_pkg::PTR_W-1:0]      send_slot_o,
  output logic [cws_pkg::SEQ_W-1:0]      send_seq_o,
  output logic [cws_pkg::LEN_W-1:0]      send_len_o,
  output logic                           enq_accepted_o,
  output logic [cws_pkg::CNT_W-1:0]      released_o,
  output logic                           retransmit_o,
  output logic [cws_pkg::CNT_W-1:0]      window_o,
  output logic [cws_pkg::THR_W-1:0]      threshold_o,
  output logic [cws_pkg::CNT_W-1:0]      queued_o,
  output logic [cws_pkg::CNT_W-1:0]      in_flight_o
);

  cws_pkg::ring_req_t ring_req;
  cws_pkg::seg_t      ring_rdata;
  cws_pkg::result_t   res_new, res_out;
  logic               res_load, res_free;

  cws_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

  cws_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .seg_len_i     (seg_len_i),
    .ack_no_i      (ack_no_i),
    .peer_window_i (peer_window_i),
    .res_free_i    (res_free),
    .res_load_o    (res_load),
    .res_o         (res_new),
    .ring_req_o    (ring_req),
    .ring_rdata_i  (ring_rdata)
  );

  cws_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res_new),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign send_valid_o   = res_out.send_valid;
  assign send_slot_o    = res_out.send_slot;
  assign send_seq_o     = res_out.send_seq;
  assign send_len_o     = res_out.send_len;
  assign enq_accepted_o = res_out.enq_accepted;
  assign released_o     = res_out.released;
  assign retransmit_o   = res_out.retransmit;
  assign window_o       = res_out.window;
  assign threshold_o    = res_out.threshold;
  assign queued_o       = res_out.queued;
  assign in_flight_o    = res_out.in_flight;

  // a new result never overwrites one the receiver is still stalling on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_load && out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (in_flight_o <= queued_o))
    else $error("more segments in flight than queued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_valid_o) |-> (in_flight_o != '0))
    else $error("issued segment not counted in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && retransmit_o) |-> (in_flight_o == '0))
    else $error("rewind left segments in flight");

endmodule
